@@ sv/klx_pkg.sv @@
`default_nettype none

package klx_pkg;

   // scan state between bytes
   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_KEYWORD,
      MODE_SLASH,
      MODE_NAME,
      MODE_NUMBER,
      MODE_STRING
   } mode_type;

   // token kinds
   localparam logic [3:0] KIND_LBRACE  = 4'd0;
   localparam logic [3:0] KIND_RBRACE  = 4'd1;
   localparam logic [3:0] KIND_LPAREN  = 4'd2;
   localparam logic [3:0] KIND_RPAREN  = 4'd3;
   localparam logic [3:0] KIND_COMMENT = 4'd4;
   localparam logic [3:0] KIND_EQUALS  = 4'd5;
   localparam logic [3:0] KIND_SEMI    = 4'd6;
   localparam logic [3:0] KIND_CPU     = 4'd7;
   localparam logic [3:0] KIND_INSTR   = 4'd8;
   localparam logic [3:0] KIND_REG     = 4'd9;
   localparam logic [3:0] KIND_NAME    = 4'd10;
   localparam logic [3:0] KIND_NUMBER  = 4'd11;
   localparam logic [3:0] KIND_STRING  = 4'd12;
   localparam logic [3:0] KIND_END     = 4'd13;

   // keyword codes
   localparam logic [1:0] KW_CPU   = 2'd0;
   localparam logic [1:0] KW_INSTR = 2'd1;
   localparam logic [1:0] KW_REG   = 2'd2;

   // characters
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_EQUALS = 8'h3D;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_C      = 8'h63;
   localparam logic [7:0] CH_I      = 8'h69;
   localparam logic [7:0] CH_R      = 8'h72;
   localparam logic [7:0] CH_0      = 8'h30;
   localparam logic [7:0] CH_9      = 8'h39;

   localparam logic [0:11][7:0] KW_CPU_TEXT   = {"cpu", {9{8'h00}}};
   localparam logic [0:11][7:0] KW_INSTR_TEXT = "instructions";
   localparam logic [0:11][7:0] KW_REG_TEXT   = {"registers", {3{8'h00}}};

   // token bundle and queue sizing
   localparam int MAX_TOKENS   = 4;
   localparam int TOK_IDX_BITS = 2;
   localparam int CNT_BITS     = 3;
   localparam int QUEUE_DEPTH  = 4;
   localparam int QPTR_BITS    = 2;
   localparam int QCNT_BITS    = 3;

   typedef struct packed {
      logic                push;
      logic [CNT_BITS-1:0] count;
   } bundle_ctrl_type;

   typedef struct packed {
      logic                empty;
      logic                full;
      logic [CNT_BITS-1:0] head_count;
   } queue_stat_type;

   function automatic logic is_space(input logic [7:0] c);
      return (c == 8'h20) || (c inside {[8'h09:8'h0D]});
   endfunction

   function automatic logic is_punct(input logic [7:0] c);
      return (c inside {[8'h21:8'h2F], [8'h3A:8'h40], [8'h5B:8'h60], [8'h7B:8'h7E]});
   endfunction

   function automatic logic [3:0] kw_len(input logic [1:0] kw);
      logic [3:0] n;
      case (kw)
         KW_CPU:   n = 4'd3;
         KW_INSTR: n = 4'd12;
         KW_REG:   n = 4'd9;
         default:  n = 4'd3;
      endcase
      return n;
   endfunction

   function automatic logic [3:0] kw_kind(input logic [1:0] kw);
      logic [3:0] k;
      case (kw)
         KW_CPU:   k = KIND_CPU;
         KW_INSTR: k = KIND_INSTR;
         KW_REG:   k = KIND_REG;
         default:  k = KIND_CPU;
      endcase
      return k;
   endfunction

   function automatic logic [7:0] kw_char(input logic [1:0] kw, input logic [3:0] idx);
      logic [7:0] ch;
      if (idx > 4'd11) begin
         ch = CH_NUL;
      end else begin
         case (kw)
            KW_CPU:   ch = KW_CPU_TEXT[idx];
            KW_INSTR: ch = KW_INSTR_TEXT[idx];
            KW_REG:   ch = KW_REG_TEXT[idx];
            default:  ch = KW_CPU_TEXT[idx];
         endcase
      end
      return ch;
   endfunction

endpackage

`default_nettype wire

@@ sv/klx_front.sv @@
`default_nettype none

module klx_front #(
   parameter int OFFSET_BITS = 24,
   parameter int LENGTH_BITS = 16
) (
   input  wire logic                                                 clock,
   input  wire logic                                                 reset,
   input  wire logic                                                 push,
   input  wire logic                                                 q_full,
   input  wire logic [7:0]                                           src_byte,
   input  wire logic                                                 end_of_source,
   output klx_pkg::bundle_ctrl_type                                  bnd,
   output logic [klx_pkg::MAX_TOKENS-1:0][3:0]                       tk_kind,
   output logic [klx_pkg::MAX_TOKENS-1:0][OFFSET_BITS-1:0]           tk_start,
   output logic [klx_pkg::MAX_TOKENS-1:0][LENGTH_BITS-1:0]           tk_len
);
   import klx_pkg::*;

   typedef struct packed {
      logic       emit_one;
      logic [3:0] kind;
      mode_type   mode;
      logic       load;
      logic       str;
      logic       kw_load;
      logic [1:0] kw;
   } start_type;

   function automatic start_type start_token(input logic [7:0] c);
      start_type s;
      s = '0;
      s.mode = MODE_IDLE;
      if (!is_space(c)) begin
         case (c)
            CH_LBRACE: begin s.emit_one = 1'b1; s.kind = KIND_LBRACE; end
            CH_RBRACE: begin s.emit_one = 1'b1; s.kind = KIND_RBRACE; end
            CH_LPAREN: begin s.emit_one = 1'b1; s.kind = KIND_LPAREN; end
            CH_RPAREN: begin s.emit_one = 1'b1; s.kind = KIND_RPAREN; end
            CH_EQUALS: begin s.emit_one = 1'b1; s.kind = KIND_EQUALS; end
            CH_SEMI:   begin s.emit_one = 1'b1; s.kind = KIND_SEMI; end
            default: begin
               s.load = 1'b1;
               if (c == CH_SLASH) begin
                  s.mode = MODE_SLASH;
               end else if (c == CH_QUOTE) begin
                  s.mode = MODE_STRING;
                  s.str  = 1'b1;
               end else if (c == CH_C || c == CH_I || c == CH_R) begin
                  s.mode    = MODE_KEYWORD;
                  s.kw_load = 1'b1;
                  s.kw      = (c == CH_C) ? KW_CPU : ((c == CH_I) ? KW_INSTR : KW_REG);
               end else if (c inside {[CH_0:CH_9]}) begin
                  s.mode = MODE_NUMBER;
               end else if (is_punct(c)) begin
                  // unlisted mark: one-character name
                  s.emit_one = 1'b1;
                  s.kind     = KIND_NAME;
               end else begin
                  s.mode = MODE_NAME;
               end
            end
         endcase
      end
      return s;
   endfunction

   function automatic logic [LENGTH_BITS-1:0] sat_inc(input logic [LENGTH_BITS-1:0] v);
      return (v == {LENGTH_BITS{1'b1}}) ? v : v + LENGTH_BITS'(1);
   endfunction

   mode_type                mode_ff, mode_in;
   logic [1:0]              kw_ff, kw_in;
   logic [3:0]              mi_ff, mi_in;
   logic [OFFSET_BITS-1:0]  ps_ff, ps_in;
   logic [LENGTH_BITS-1:0]  pl_ff, pl_in;
   logic [OFFSET_BITS-1:0]  pos_ff, pos_in;
   logic                    fin_ff, fin_in;

   logic                    accept;
   start_type               st;
   logic                    do_start;
   logic                    do_finish;
   logic [CNT_BITS-1:0]     cnt;
   logic                    kw_hit;

   assign accept = push && !q_full;

   always_comb begin
      st        = start_token(src_byte);
      cnt       = '0;
      tk_kind   = '0;
      tk_start  = '0;
      tk_len    = '0;
      mode_in   = mode_ff;
      kw_in     = kw_ff;
      mi_in     = mi_ff;
      ps_in     = ps_ff;
      pl_in     = pl_ff;
      pos_in    = pos_ff;
      fin_in    = fin_ff;
      do_start  = 1'b0;
      do_finish = 1'b0;
      kw_hit    = (mi_ff < kw_len(kw_ff)) && (src_byte == kw_char(kw_ff, mi_ff));
      if (accept && !fin_ff) begin
         if (src_byte == CH_NUL) begin
            do_finish = 1'b1;
         end else begin
            pos_in    = pos_ff + OFFSET_BITS'(1);
            do_finish = end_of_source;
            case (mode_ff)
               MODE_KEYWORD: begin
                  if (kw_hit) begin
                     mi_in = mi_ff + 4'd1;
                     pl_in = sat_inc(pl_ff);
                     if (mi_in >= kw_len(kw_ff)) begin
                        tk_kind[cnt[TOK_IDX_BITS-1:0]]  = kw_kind(kw_ff);
                        tk_start[cnt[TOK_IDX_BITS-1:0]] = ps_ff;
                        tk_len[cnt[TOK_IDX_BITS-1:0]]   = LENGTH_BITS'(kw_len(kw_ff));
                        cnt     = cnt + CNT_BITS'(1);
                        mode_in = MODE_IDLE;
                        mi_in   = 4'd0;
                     end
                  end else if (is_space(src_byte) || is_punct(src_byte)) begin
                     tk_kind[cnt[TOK_IDX_BITS-1:0]]  = KIND_NAME;
                     tk_start[cnt[TOK_IDX_BITS-1:0]] = ps_ff;
                     tk_len[cnt[TOK_IDX_BITS-1:0]]   = pl_ff;
                     cnt      = cnt + CNT_BITS'(1);
                     mi_in    = 4'd0;
                     do_start = 1'b1;
                  end else begin
                     // broken keyword continues as a name
                     mode_in = MODE_NAME;
                     mi_in   = 4'd0;
                     pl_in   = sat_inc(pl_ff);
                  end
               end
               MODE_SLASH: begin
                  if (src_byte == CH_SLASH) begin
                     tk_kind[cnt[TOK_IDX_BITS-1:0]]  = KIND_COMMENT;
                     tk_start[cnt[TOK_IDX_BITS-1:0]] = ps_ff;
                     tk_len[cnt[TOK_IDX_BITS-1:0]]   = LENGTH_BITS'(2);
                     cnt     = cnt + CNT_BITS'(1);
                     mode_in = MODE_IDLE;
                  end else begin
                     tk_kind[cnt[TOK_IDX_BITS-1:0]]  = KIND_NAME;
                     tk_start[cnt[TOK_IDX_BITS-1:0]] = ps_ff;
                     tk_len[cnt[TOK_IDX_BITS-1:0]]   = LENGTH_BITS'(1);
                     cnt      = cnt + CNT_BITS'(1);
                     do_start = 1'b1;
                  end
               end
               MODE_NAME, MODE_NUMBER: begin
                  if (is_space(src_byte) || is_punct(src_byte)) begin
                     tk_kind[cnt[TOK_IDX_BITS-1:0]]  =
                        (mode_ff == MODE_NAME) ? KIND_NAME : KIND_NUMBER;
                     tk_start[cnt[TOK_IDX_BITS-1:0]] = ps_ff;
                     tk_len[cnt[TOK_IDX_BITS-1:0]]   = pl_ff;
                     cnt      = cnt + CNT_BITS'(1);
                     do_start = 1'b1;
                  end else begin
                     pl_in = sat_inc(pl_ff);
                  end
               end
               MODE_STRING: begin
                  if (src_byte == CH_QUOTE) begin
                     tk_kind[cnt[TOK_IDX_BITS-1:0]]  = KIND_STRING;
                     tk_start[cnt[TOK_IDX_BITS-1:0]] = ps_ff;
                     tk_len[cnt[TOK_IDX_BITS-1:0]]   = pl_ff;
                     cnt     = cnt + CNT_BITS'(1);
                     mode_in = MODE_IDLE;
                  end else begin
                     pl_in = sat_inc(pl_ff);
                  end
               end
               default: begin
                  do_start = 1'b1;
               end
            endcase
            // open a new token on this byte after any token it closed
            if (do_start) begin
               mode_in = st.mode;
               if (st.emit_one) begin
                  tk_kind[cnt[TOK_IDX_BITS-1:0]]  = st.kind;
                  tk_start[cnt[TOK_IDX_BITS-1:0]] = pos_ff;
                  tk_len[cnt[TOK_IDX_BITS-1:0]]   = LENGTH_BITS'(1);
                  cnt = cnt + CNT_BITS'(1);
               end
               if (st.load) begin
                  ps_in = st.str ? pos_ff + OFFSET_BITS'(1) : pos_ff;
                  pl_in = st.str ? '0 : LENGTH_BITS'(1);
               end
               if (st.kw_load) begin
                  kw_in = st.kw;
                  mi_in = 4'd1;
               end
            end
         end
         // flush the open token, then give the end token
         if (do_finish) begin
            case (mode_in)
               MODE_KEYWORD, MODE_NAME: begin
                  tk_kind[cnt[TOK_IDX_BITS-1:0]]  = KIND_NAME;
                  tk_start[cnt[TOK_IDX_BITS-1:0]] = ps_in;
                  tk_len[cnt[TOK_IDX_BITS-1:0]]   = pl_in;
                  cnt = cnt + CNT_BITS'(1);
               end
               MODE_NUMBER: begin
                  tk_kind[cnt[TOK_IDX_BITS-1:0]]  = KIND_NUMBER;
                  tk_start[cnt[TOK_IDX_BITS-1:0]] = ps_in;
                  tk_len[cnt[TOK_IDX_BITS-1:0]]   = pl_in;
                  cnt = cnt + CNT_BITS'(1);
               end
               MODE_SLASH: begin
                  tk_kind[cnt[TOK_IDX_BITS-1:0]]  = KIND_NAME;
                  tk_start[cnt[TOK_IDX_BITS-1:0]] = ps_in;
                  tk_len[cnt[TOK_IDX_BITS-1:0]]   = LENGTH_BITS'(1);
                  cnt = cnt + CNT_BITS'(1);
               end
               MODE_STRING: begin
                  tk_kind[cnt[TOK_IDX_BITS-1:0]]  = KIND_STRING;
                  tk_start[cnt[TOK_IDX_BITS-1:0]] = ps_in;
                  tk_len[cnt[TOK_IDX_BITS-1:0]]   = pl_in;
                  cnt = cnt + CNT_BITS'(1);
               end
               default: begin
               end
            endcase
            tk_kind[cnt[TOK_IDX_BITS-1:0]]  = KIND_END;
            tk_start[cnt[TOK_IDX_BITS-1:0]] = pos_in;
            tk_len[cnt[TOK_IDX_BITS-1:0]]   = '0;
            cnt     = cnt + CNT_BITS'(1);
            mode_in = MODE_IDLE;
            mi_in   = 4'd0;
            fin_in  = 1'b1;
         end
      end
   end

   always_comb begin
      bnd.push  = (cnt != '0);
      bnd.count = cnt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         kw_ff   <= KW_CPU;
         mi_ff   <= '0;
         ps_ff   <= '0;
         pl_ff   <= '0;
         pos_ff  <= '0;
         fin_ff  <= 1'b0;
      end else begin
         mode_ff <= mode_in;
         kw_ff   <= kw_in;
         mi_ff   <= mi_in;
         ps_ff   <= ps_in;
         pl_ff   <= pl_in;
         pos_ff  <= pos_in;
         fin_ff  <= fin_in;
      end
   end

endmodule

`default_nettype wire

@@ sv/klx_queue.sv @@
`default_nettype none

module klx_queue #(
   parameter int OFFSET_BITS = 24,
   parameter int LENGTH_BITS = 16
) (
   input  wire logic                                                 clock,
   input  wire logic                                                 reset,
   input  wire klx_pkg::bundle_ctrl_type                             bnd,
   input  wire logic [klx_pkg::MAX_TOKENS-1:0][3:0]                  wr_kind,
   input  wire logic [klx_pkg::MAX_TOKENS-1:0][OFFSET_BITS-1:0]      wr_start,
   input  wire logic [klx_pkg::MAX_TOKENS-1:0][LENGTH_BITS-1:0]      wr_len,
   input  wire logic                                                 q_pop,
   output klx_pkg::queue_stat_type                                   q_stat,
   output logic [klx_pkg::MAX_TOKENS-1:0][3:0]                       hd_kind,
   output logic [klx_pkg::MAX_TOKENS-1:0][OFFSET_BITS-1:0]           hd_start,
   output logic [klx_pkg::MAX_TOKENS-1:0][LENGTH_BITS-1:0]           hd_len
);
   import klx_pkg::*;

   logic [CNT_BITS-1:0]                         cnt_ff   [QUEUE_DEPTH];
   logic [MAX_TOKENS-1:0][3:0]                  kind_ff  [QUEUE_DEPTH];
   logic [MAX_TOKENS-1:0][OFFSET_BITS-1:0]      start_ff [QUEUE_DEPTH];
   logic [MAX_TOKENS-1:0][LENGTH_BITS-1:0]      len_ff   [QUEUE_DEPTH];

   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0] fill_ff, fill_in;

   always_comb begin
      wr_ptr_in = bnd.push ? wr_ptr_ff + QPTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + QPTR_BITS'(1) : rd_ptr_ff;
      fill_in   = fill_ff + QCNT_BITS'(bnd.push) - QCNT_BITS'(q_pop);
   end

   always_comb begin
      q_stat.empty      = (fill_ff == '0);
      q_stat.full       = (fill_ff == QCNT_BITS'(QUEUE_DEPTH));
      q_stat.head_count = cnt_ff[rd_ptr_ff];
      hd_kind           = kind_ff[rd_ptr_ff];
      hd_start          = start_ff[rd_ptr_ff];
      hd_len            = len_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (bnd.push) begin
         cnt_ff[wr_ptr_ff]   <= bnd.count;
         kind_ff[wr_ptr_ff]  <= wr_kind;
         start_ff[wr_ptr_ff] <= wr_start;
         len_ff[wr_ptr_ff]   <= wr_len;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

`default_nettype wire

@@ sv/klx_back.sv @@
`default_nettype none

module klx_back #(
   parameter int OFFSET_BITS = 24,
   parameter int LENGTH_BITS = 16
) (
   input  wire logic                                                 clock,
   input  wire logic                                                 reset,
   input  wire klx_pkg::queue_stat_type                              q_stat,
   input  wire logic [klx_pkg::MAX_TOKENS-1:0][3:0]                  hd_kind,
   input  wire logic [klx_pkg::MAX_TOKENS-1:0][OFFSET_BITS-1:0]      hd_start,
   input  wire logic [klx_pkg::MAX_TOKENS-1:0][LENGTH_BITS-1:0]      hd_len,
   output logic                                                      q_pop,
   output logic                                                      empty,
   input  wire logic                                                 pop,
   output logic [3:0]                                                token_kind,
   output logic [OFFSET_BITS-1:0]                                    token_start,
   output logic [LENGTH_BITS-1:0]                                    token_len,
   output logic                                                      last_of_run
);
   import klx_pkg::*;

   logic                    vld_ff, vld_in;
   logic [TOK_IDX_BITS-1:0] idx_ff, idx_in;
   logic [3:0]              kind_ff;
   logic [OFFSET_BITS-1:0]  start_ff;
   logic [LENGTH_BITS-1:0]  len_ff;
   logic                    last_ff;

   logic                    load;
   logic                    tok_last;

   always_comb begin
      load     = !q_stat.empty && (!vld_ff || pop);
      tok_last = ((CNT_BITS'(idx_ff) + CNT_BITS'(1)) == q_stat.head_count);
      q_pop    = load && tok_last;
      idx_in   = idx_ff;
      if (load) begin
         idx_in = tok_last ? '0 : idx_ff + TOK_IDX_BITS'(1);
      end
      if (load) begin
         vld_in = 1'b1;
      end else if (pop) begin
         vld_in = 1'b0;
      end else begin
         vld_in = vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
         idx_ff <= '0;
      end else begin
         vld_ff <= vld_in;
         idx_ff <= idx_in;
      end
   end

   // output reg takes one head-bundle token per cycle if free or popped
   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff  <= hd_kind[idx_ff];
         start_ff <= hd_start[idx_ff];
         len_ff   <= hd_len[idx_ff];
         last_ff  <= tok_last;
      end
   end

   assign empty       = !vld_ff;
   assign token_kind  = kind_ff;
   assign token_start = start_ff;
   assign token_len   = len_ff;
   assign last_of_run = last_ff;

endmodule

`default_nettype wire

@@ sv/keyword_token_lexer_core.sv @@
// Keyword token lexer: source bytes in, tokens (kind, start, length) out.
// Input side is a queue write port: drive req_src_byte/req_end_of_source
// with push; a byte is taken on a clock edge where push is high and full
// is low. A zero byte or end_of_source closes the source and gives the
// end token; bytes after that are taken and dropped until reset.
// Result side is a queue read port: while empty is low the oldest token
// sits on rsp_token_*; pop high at a clock edge takes it. rsp_last_of_run
// marks the final token caused by one byte.
// A token goes from the scanner through the bundle queue and the output
// register to the result ports. Throughput: one byte per cycle into the
// scanner while full is low; the output drains one token per cycle while
// pop is high, so a byte that closes one token and opens another takes
// one output slot per token. A four-entry bundle queue between scanner
// and output register absorbs the difference; full rises once it holds
// four bundles, as when pop is held low while bytes keep making tokens.
// Reset (synchronous) clears position, scan state, queue and output valid.
`default_nettype none

module keyword_token_lexer_core #(
   parameter int OFFSET_BITS = 24,
   parameter int LENGTH_BITS = 16
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push,
   output logic                         full,
   input  wire logic [7:0]              req_src_byte,
   input  wire logic                    req_end_of_source,
   output logic                         empty,
   input  wire logic                    pop,
   output logic [3:0]                   rsp_token_kind,
   output logic [OFFSET_BITS-1:0]       rsp_token_start,
   output logic [LENGTH_BITS-1:0]       rsp_token_len,
   output logic                         rsp_last_of_run
);
   import klx_pkg::*;

   bundle_ctrl_type                         bnd;
   queue_stat_type                          q_stat;
   logic                                    q_pop;
   logic [MAX_TOKENS-1:0][3:0]              tk_kind;
   logic [MAX_TOKENS-1:0][OFFSET_BITS-1:0]  tk_start;
   logic [MAX_TOKENS-1:0][LENGTH_BITS-1:0]  tk_len;
   logic [MAX_TOKENS-1:0][3:0]              hd_kind;
   logic [MAX_TOKENS-1:0][OFFSET_BITS-1:0]  hd_start;
   logic [MAX_TOKENS-1:0][LENGTH_BITS-1:0]  hd_len;

   assign full = q_stat.full;

   klx_front #(
      .OFFSET_BITS (OFFSET_BITS),
      .LENGTH_BITS (LENGTH_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .q_full        (q_stat.full),
      .src_byte      (req_src_byte),
      .end_of_source (req_end_of_source),
      .bnd           (bnd),
      .tk_kind       (tk_kind),
      .tk_start      (tk_start),
      .tk_len        (tk_len)
   );

   klx_queue #(
      .OFFSET_BITS (OFFSET_BITS),
      .LENGTH_BITS (LENGTH_BITS)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .bnd      (bnd),
      .wr_kind  (tk_kind),
      .wr_start (tk_start),
      .wr_len   (tk_len),
      .q_pop    (q_pop),
      .q_stat   (q_stat),
      .hd_kind  (hd_kind),
      .hd_start (hd_start),
      .hd_len   (hd_len)
   );

   klx_back #(
      .OFFSET_BITS (OFFSET_BITS),
      .LENGTH_BITS (LENGTH_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_stat       (q_stat),
      .hd_kind      (hd_kind),
      .hd_start     (hd_start),
      .hd_len       (hd_len),
      .q_pop        (q_pop),
      .empty        (empty),
      .pop          (pop),
      .token_kind   (rsp_token_kind),
      .token_start  (rsp_token_start),
      .token_len    (rsp_token_len),
      .last_of_run  (rsp_last_of_run)
   );

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      bnd.push |-> !q_stat.full)
      else $error("bundle written into a full queue");

   a_bundle_size: assert property (@(posedge clock) disable iff (reset)
      bnd.push |-> (bnd.count <= CNT_BITS'(MAX_TOKENS)))
      else $error("bundle holds more tokens than it has slots");

   a_head_nonzero: assert property (@(posedge clock) disable iff (reset)
      !q_stat.empty |-> (q_stat.head_count != '0))
      else $error("queue head bundle has no tokens");

   a_pop_needs_data: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_stat.empty)
      else $error("queue popped while empty");
`endif

endmodule

`default_nettype wire
